// ----- hdl/bbl_pkg.sv -----
`default_nettype none

package bbl_pkg;

    // pixel layout: red in the low byte, then green, then blue
    localparam int PIX_W    = 8;
    localparam int NUM_CH   = 3;
    localparam int PIXEL_W  = PIX_W * NUM_CH;

    // 7x7 window, six earlier rows held per column
    localparam int TAPS     = 7;
    localparam int HALO     = 3;
    localparam int LB_ROWS  = TAPS - 1;
    localparam int WORD_W   = LB_ROWS * PIXEL_W;

    // 7 * 255 and 49 * 255
    localparam int COLSUM_W = 11;
    localparam int SUM_W    = 14;

    // round(sum / 49) = floor((2 * sum + 49) / 98) = ((2 * sum + 49) * 42800) >> 22
    localparam int                  NUM_W      = SUM_W + 1;
    localparam int                  DIV_MUL_W  = 16;
    localparam logic [DIV_MUL_W-1:0] DIV_MUL   = 16'd42800;
    localparam int                  DIV_SHIFT  = 22;
    localparam logic [NUM_W-1:0]    ROUND_BIAS = 15'd49;

    // configuration registers
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 12'd640;
    localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;

    // per-item control that travels with the pixel
    typedef struct packed {
        logic            produce;  // item releases one result
        logic            last;     // that result closes the frame
        logic [TAPS-1:0] rmask;    // rows y-k inside the frame, k = 0..6
        logic [TAPS-1:0] cmask;    // window taps inside the center row
    } t_tag;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] t_sums;

endpackage

`default_nettype wire

// ----- hdl/rgb_box_blur_7x7.sv -----
`default_nettype none

// channel   direction  signals                          content
// s_axis    in         tvalid tready tdata[23:0] tuser  pixel, tuser = drain tick
// m_axis    out        tvalid tready tdata[23:0] tlast  blurred pixel, tlast = frame end
// cfg       in         i_cfg_we i_cfg_addr i_cfg_data    0 = frame_width, 1 = frame_height
//
// one item per cycle while s_axis_tready is high; a result leaves through the line read, column sum,
// window, window sum and output register stages
// results lag the input by 3 * frame_width + 3 items, flushed by drain ticks after the frame
// s_axis_tready drops only when all five stages hold items and m_axis_tready is low
// synchronous reset clears counters and stage valids; the line store needs no clearing

module rgb_box_blur_7x7 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [23:0]                    s_axis_tdata,  // red_in, green_in, blue_in
    input  wire logic                           s_axis_tuser,  // func
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [23:0]                         m_axis_tdata,  // red_out, green_out, blue_out
    output logic                                m_axis_tlast,  // last
    input  wire logic                           i_cfg_we,
    input  wire logic [bbl_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [bbl_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bbl_pkg::*;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 8);
    localparam int CMP_W  = $clog2(MAX_WIDTH + 8);
    localparam int LAG_W  = $clog2(3 * MAX_WIDTH + 4);

    function automatic logic [WID_W-1:0] clamp_w(input logic [WIDTH_REG_W-1:0] v);
        logic [31:0] x;
        x = {{(32-WIDTH_REG_W){1'b0}}, v};
        if (x == 32'd0) begin
            x = 32'd1;
        end else if (x > 32'(MAX_WIDTH)) begin
            x = 32'(MAX_WIDTH);
        end
        return WID_W'(x);
    endfunction

    function automatic logic [HGT_W-1:0] clamp_h(input logic [HEIGHT_REG_W-1:0] v);
        logic [31:0] x;
        x = {{(32-HEIGHT_REG_W){1'b0}}, v};
        if (x == 32'd0) begin
            x = 32'd1;
        end else if (x > 32'(MAX_HEIGHT)) begin
            x = 32'(MAX_HEIGHT);
        end
        return HGT_W'(x);
    endfunction

    logic [WID_W-1:0]  r_w;
    logic [HGT_W-1:0]  r_h;
    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;
    logic [ADDR_W-1:0] r_ocol;
    logic [HGT_W-1:0]  r_orow;
    logic [LAG_W-1:0]  r_lead;

    logic               r1_valid;
    logic [PIXEL_W-1:0] r1_pix;
    t_tag               r1_tag;

    logic               s_acc;
    logic               in_frame;
    logic               w_item;
    logic [LAG_W-1:0]   w_lag;
    logic               col_wrap;
    logic               ocol_wrap;
    logic [CMP_W-1:0]   ocol3;
    logic [PIXEL_W-1:0] n_pix;
    t_tag               n_tag;
    logic               en1;

    logic [WORD_W-1:0]  lb_word;
    logic               win_ready;
    logic               win_valid;
    t_sums              win_sum;
    logic               win_last;
    logic               out_ready;

    // handshake on the input side
    assign en1           = !r1_valid || win_ready;
    assign s_axis_tready = en1;
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // a drain tick inside the frame is dropped; data after the frame counts as drain
    assign in_frame = ROW_W'(r_row) < ROW_W'(r_h);
    assign w_item   = s_acc && !(in_frame && s_axis_tuser);
    assign n_pix    = in_frame ? s_axis_tdata : '0;

    // delay between input and output raster positions
    assign w_lag     = (LAG_W'(r_w) << 1) + LAG_W'(r_w) + LAG_W'(3);
    assign col_wrap  = (WID_W'(r_col) + WID_W'(1)) == r_w;
    assign ocol_wrap = (WID_W'(r_ocol) + WID_W'(1)) == r_w;
    assign ocol3     = CMP_W'(r_ocol) + CMP_W'(HALO);

    // item tag: result release, frame end, row and column masks
    always_comb begin
        n_tag.produce = (r_lead == w_lag);
        n_tag.last    = n_tag.produce && ocol_wrap &&
                        ((HGT_W'(r_orow) + HGT_W'(1)) == r_h);
        for (int k = 0; k < TAPS; k++) begin
            n_tag.rmask[k] = (r_row >= ROW_W'(k)) &&
                             (r_row < ROW_W'(r_h) + ROW_W'(k));
        end
        for (int j = 0; j < TAPS; j++) begin
            n_tag.cmask[j] = (ocol3 >= CMP_W'(j)) &&
                             (ocol3 < CMP_W'(r_w) + CMP_W'(j));
        end
    end

    // frame size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= clamp_w(RESET_WIDTH);
            r_h <= clamp_h(RESET_HEIGHT);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FRAME_WIDTH:  r_w <= clamp_w(i_cfg_data[WIDTH_REG_W-1:0]);
                CFG_FRAME_HEIGHT: r_h <= clamp_h(i_cfg_data[HEIGHT_REG_W-1:0]);
            endcase
        end
    end

    // raster counters; a frame restarts on a register write or after its last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ocol <= '0;
            r_orow <= '0;
            r_lead <= '0;
        end else if (w_item) begin
            if (n_tag.last) begin
                r_col  <= '0;
                r_row  <= '0;
                r_ocol <= '0;
                r_orow <= '0;
                r_lead <= '0;
            end else begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + ADDR_W'(1);
                end
                if (!n_tag.produce) begin
                    r_lead <= r_lead + LAG_W'(1);
                end else if (ocol_wrap) begin
                    r_ocol <= '0;
                    r_orow <= r_orow + HGT_W'(1);
                end else begin
                    r_ocol <= r_ocol + ADDR_W'(1);
                end
            end
        end
    end

    // input stage, alongside the line store read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en1) begin
            r1_valid <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_item) begin
            r1_pix <= n_pix;
            r1_tag <= n_tag;
        end
    end

    bbl_line_buf #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_item),
        .i_rd_addr (r_col),
        .i_pix     (r1_pix),
        .o_word    (lb_word)
    );

    bbl_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_valid),
        .o_ready (win_ready),
        .i_pix   (r1_pix),
        .i_word  (lb_word),
        .i_tag   (r1_tag),
        .o_valid (win_valid),
        .i_ready (out_ready),
        .o_sum   (win_sum),
        .o_last  (win_last)
    );

    bbl_round49 u_round49 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (win_valid),
        .o_ready  (out_ready),
        .i_sum    (win_sum),
        .i_last   (win_last),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

    // the lead counter stops at the lag
    a_lead_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lead <= w_lag)
        else $error("lead counter ran past the lag");

    // the output row stays inside the frame
    a_orow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_orow < r_h)
        else $error("output row beyond frame height");

    // once results flow, input column sits three columns past the output column
    a_col_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lead == w_lag) && (r_w >= WID_W'(3)) |->
        ((ocol3 == CMP_W'(r_col)) || (ocol3 == CMP_W'(r_col) + CMP_W'(r_w))))
        else $error("input and output positions out of step");

endmodule

`default_nettype wire

// ----- hdl/bbl_line_buf.sv -----
`default_nettype none

module bbl_line_buf #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_rd_en,
    input  wire logic [ADDR_W-1:0]          i_rd_addr,
    input  wire logic [bbl_pkg::PIXEL_W-1:0] i_pix,
    output logic      [bbl_pkg::WORD_W-1:0] o_word
);
    import bbl_pkg::*;

    // one word per column: the six earlier rows, nearest row in the low slot
    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd;
    logic [WORD_W-1:0] r_byp_word;
    logic              r_byp;
    logic              r_wr_en;
    logic [ADDR_W-1:0] r_wr_addr;
    logic [WORD_W-1:0] wr_word;

    // shift the column up by one row and put the new pixel in
    assign o_word  = r_byp ? r_byp_word : r_rd;
    assign wr_word = {o_word[WORD_W-PIXEL_W-1:0], i_pix};

    // write back in the cycle after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= i_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_wr_en) begin
            r_mem[r_wr_addr] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    // forward the pending write when a one-pixel row reads the same column
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_wr_addr  <= i_rd_addr;
            r_byp      <= r_wr_en && (r_wr_addr == i_rd_addr);
            r_byp_word <= wr_word;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bbl_window.sv -----
`default_nettype none

module bbl_window (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [bbl_pkg::PIXEL_W-1:0] i_pix,
    input  wire logic [bbl_pkg::WORD_W-1:0]  i_word,
    input  wire bbl_pkg::t_tag               i_tag,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output bbl_pkg::t_sums                   o_sum,
    output logic                             o_last
);
    import bbl_pkg::*;

    typedef logic [NUM_CH-1:0][COLSUM_W-1:0] t_colsums;

    logic     r2_valid, r3_valid, r4_valid;
    t_colsums r2_cs;
    t_tag     r2_tag, r3_tag;
    t_colsums r_win [TAPS];
    t_sums    r4_sum;
    logic     r4_last;
    t_colsums n_cs;
    t_sums    n_sum;
    logic     en2, en3, en4;

    // stage enables, a stage loads when it is empty or drains
    assign en4     = !r4_valid || i_ready;
    assign en3     = !r3_valid || en4;
    assign en2     = !r2_valid || en3;
    assign o_ready = en2;

    // vertical sum over the seven rows of this column
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_cs[ch] = '0;
            if (i_tag.rmask[0]) begin
                n_cs[ch] = COLSUM_W'(i_pix[ch*PIX_W +: PIX_W]);
            end
            for (int k = 1; k < TAPS; k++) begin
                if (i_tag.rmask[k]) begin
                    n_cs[ch] = n_cs[ch] +
                        COLSUM_W'(i_word[(k-1)*PIXEL_W + ch*PIX_W +: PIX_W]);
                end
            end
        end
    end

    // horizontal sum over the taps that lie in the center row
    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            n_sum[ch] = '0;
            for (int j = 0; j < TAPS; j++) begin
                if (r3_tag.cmask[j]) begin
                    n_sum[ch] = n_sum[ch] + SUM_W'(r_win[j][ch]);
                end
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en2) begin
                r2_valid <= i_valid;
            end
            if (en3) begin
                r3_valid <= r2_valid;
            end
            if (en4) begin
                r4_valid <= r3_valid && r3_tag.produce;
            end
        end
    end

    // column sums
    always_ff @(posedge i_clk) begin
        if (en2 && i_valid) begin
            r2_cs  <= n_cs;
            r2_tag <= i_tag;
        end
    end

    // window of the last seven column sums, newest in tap 0
    always_ff @(posedge i_clk) begin
        if (en3 && r2_valid) begin
            r_win[0] <= r2_cs;
            for (int j = 1; j < TAPS; j++) begin
                r_win[j] <= r_win[j-1];
            end
            r3_tag <= r2_tag;
        end
    end

    // window sums
    always_ff @(posedge i_clk) begin
        if (en4 && r3_valid) begin
            r4_sum  <= n_sum;
            r4_last <= r3_tag.last;
        end
    end

    assign o_valid = r4_valid;
    assign o_sum   = r4_sum;
    assign o_last  = r4_last;

endmodule

`default_nettype wire

// ----- hdl/bbl_round49.sv -----
`default_nettype none

module bbl_round49 (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire bbl_pkg::t_sums              i_sum,
    input  wire logic                        i_last,
    output logic                             o_tvalid,
    input  wire logic                        i_tready,
    output logic [bbl_pkg::PIXEL_W-1:0]      o_tdata,
    output logic                             o_tlast
);
    import bbl_pkg::*;

    logic                r_valid;
    logic [PIXEL_W-1:0]  r_data;
    logic                r_last;
    logic [PIXEL_W-1:0]  n_data;
    logic [NUM_W-1:0]    num;
    logic [NUM_W+DIV_MUL_W-1:0] prod;
    logic                en;

    assign en      = !r_valid || i_tready;
    assign o_ready = en;

    // round half up of sum / 49 by reciprocal multiply, exact for every 49-pixel sum
    always_comb begin
        num  = '0;
        prod = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            num  = {i_sum[ch], 1'b0} + ROUND_BIAS;
            prod = (NUM_W + DIV_MUL_W)'(num) * (NUM_W + DIV_MUL_W)'(DIV_MUL);
            n_data[ch*PIX_W +: PIX_W] = prod[DIV_SHIFT +: PIX_W];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_data <= n_data;
            r_last <= i_last;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tlast  = r_last;

endmodule

`default_nettype wire

// ----- tb/sv/box_blur_checker.sv -----
module box_blur_checker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [23:0]                    s_axis_tdata,  // red_in, green_in, blue_in
    input  wire logic                           s_axis_tuser,  // func
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [23:0]                    m_axis_tdata,  // red_out, green_out, blue_out
    input  wire logic                           m_axis_tlast,  // last
    input  wire logic                           i_cfg_we,
    input  wire logic [bbl_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [bbl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bbl_pkg::*;

    localparam int STORE_DEPTH = 7 * MAX_WIDTH;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } t_blur_px;

    // own copy of the frame pixels, registers and raster positions
    logic [23:0]             frame_pixels [STORE_DEPTH];
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [HEIGHT_REG_W-1:0] height_reg;
    int unsigned             in_row;
    int unsigned             in_col;
    int unsigned             out_row;
    int unsigned             out_col;
    int unsigned             item_cnt;
    t_blur_px                blurred_q [$];

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned vmax);
        if (v == 0) return 1;
        return (v > vmax) ? vmax : v;
    endfunction

    // round half up of sum / 49 in integers
    function automatic logic [7:0] div49_round(int unsigned s);
        return 8'((2 * s + 49) / 98);
    endfunction

    function automatic void restart_frame();
        in_row   = 0;
        in_col   = 0;
        out_row  = 0;
        out_col  = 0;
        item_cnt = 0;
    endfunction

    // advance the frame by one input transaction, queue the blurred pixel it releases
    function automatic void blur_step(input logic func, input logic [23:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned lag;
        int          dy;
        int          dx;
        int          ny;
        int          nx;
        int unsigned sr;
        int unsigned sg;
        int unsigned sb;
        logic [23:0] tap;
        t_blur_px    res;
        w   = clamp_dim(width_reg, MAX_WIDTH);
        h   = clamp_dim(height_reg, MAX_HEIGHT);
        lag = 3 * w + 3;
        // inside the frame: drain ticks are ignored, pixels are stored
        if (in_row < h) begin
            if (func) return;
            frame_pixels[(in_row * w + in_col) % STORE_DEPTH] = px;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        item_cnt++;
        if (item_cnt <= lag) return;
        // 7x7 neighborhood, taps outside the frame count as zero
        sr = 0;
        sg = 0;
        sb = 0;
        for (dy = -3; dy <= 3; dy++) begin
            ny = int'(out_row) + dy;
            if (ny < 0 || ny >= int'(h)) continue;
            for (dx = -3; dx <= 3; dx++) begin
                nx = int'(out_col) + dx;
                if (nx < 0 || nx >= int'(w)) continue;
                tap = frame_pixels[(unsigned'(ny) * w + unsigned'(nx)) % STORE_DEPTH];
                sr += tap[7:0];
                sg += tap[15:8];
                sb += tap[23:16];
            end
        end
        res.last = 1'b0;
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
        if (out_row >= h) begin
            res.last = 1'b1;
            restart_frame();
        end
        res.red   = div49_round(sr);
        res.green = div49_round(sg);
        res.blue  = div49_round(sb);
        blurred_q.push_back(res);
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endfunction

    // watch config writes and both stream channels
    always @(posedge i_clk) begin
        t_blur_px exp_px;
        if (!i_rst_n) begin
            width_reg  = RESET_WIDTH;
            height_reg = RESET_HEIGHT;
            restart_frame();
            blurred_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_FRAME_WIDTH) begin
                    width_reg = i_cfg_data[WIDTH_REG_W-1:0];
                end else if (i_cfg_addr == CFG_FRAME_HEIGHT) begin
                    height_reg = i_cfg_data[HEIGHT_REG_W-1:0];
                end
                restart_frame();
            end
            // output transaction against the oldest expected pixel
            if (m_axis_tvalid && m_axis_tready) begin
                if (blurred_q.size() == 0) begin
                    $error("result with nothing expected: tdata %h tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    o_fail_count++;
                end else begin
                    exp_px = blurred_q.pop_front();
                    check_field("red_out", exp_px.red, m_axis_tdata[7:0]);
                    check_field("green_out", exp_px.green, m_axis_tdata[15:8]);
                    check_field("blue_out", exp_px.blue, m_axis_tdata[23:16]);
                    check_field("last", exp_px.last, m_axis_tlast);
                end
            end
            // input transaction
            if (s_axis_tvalid && s_axis_tready) begin
                blur_step(s_axis_tuser, s_axis_tdata);
            end
        end
        o_pending = blurred_q.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bbl_pkg::*;

    localparam int MAX_WIDTH     = 2048;
    localparam int MAX_HEIGHT    = 4096;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 200;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;  // red_in, green_in, blue_in
    logic                  s_axis_tuser  = 1'b0;  // func
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [23:0]           m_axis_tdata;  // red_out, green_out, blue_out
    logic                  m_axis_tlast;  // last
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    int fail_count;
    int pending;
    int idle_pct   = 0;
    bit hold_req   = 1'b0;
    bit frame_open = 1'b0;
    int cycle_cnt  = 0;
    int items_done = 0;
    int cur_w      = RESET_WIDTH;
    int cur_h      = RESET_HEIGHT;

    always #5 i_clk = ~i_clk;

    rgb_box_blur_7x7 #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    box_blur_checker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("[rgb_box_blur_7x7] ERROR");
            $finish;
        end
    end

    // output side: random stalls, one long hold on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(19, 1)) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic int eff_dim(int raw, int vmax);
        if (raw == 0) return 1;
        return (raw > vmax) ? vmax : raw;
    endfunction

    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(7))
            0: return 24'h000000;
            1: return 24'hFFFFFF;
            2: return {($urandom_range(1) ? 8'hFF : 8'h00),
                       ($urandom_range(1) ? 8'hFF : 8'h00),
                       ($urandom_range(1) ? 8'hFF : 8'h00)};
            default: return 24'($urandom);
        endcase
    endfunction

    // offer one item, with an optional gap first, and wait for its transaction
    task automatic offer(input logic func, input logic [23:0] data);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(19, 1)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // stop offering until every expected pixel has come out
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= CFG_DATA_W'(val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // register writes only once the pipeline has emptied
    task automatic configure(input bit do_w, input int w_raw, input bit do_h, input int h_raw);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (do_w) begin
            write_reg(CFG_FRAME_WIDTH, w_raw);
            cur_w = eff_dim(w_raw & 12'hFFF, MAX_WIDTH);
        end
        if (do_h) begin
            write_reg(CFG_FRAME_HEIGHT, h_raw);
            cur_h = eff_dim(h_raw, MAX_HEIGHT);
        end
        frame_open = 1'b0;
    endtask

    // n_pix pixels of the current frame; a complete frame is flushed with drain items
    task automatic run_frame(input int n_pix, input int noise_pct, input int hold_at,
                             input int pause_at);
        int lag;
        lag = 3 * cur_w + 3;
        for (int i = 0; i < n_pix; i++) begin
            if ($urandom_range(99) < noise_pct) offer(1'b1, 24'($urandom));
            if (i == hold_at) hold_req = 1'b1;
            if (i == pause_at) wait_results();
            offer(1'b0, rand_pixel());
            items_done++;
        end
        frame_open = (n_pix != cur_w * cur_h);
        if (!frame_open) begin
            for (int i = 0; i < lag; i++) begin
                // a data pixel after the frame end acts as a drain tick
                if ($urandom_range(99) < 20) offer(1'b0, 24'($urandom));
                else offer(1'b1, 24'($urandom));
                items_done++;
            end
        end
    endtask

    task automatic random_frame();
        int w;
        int h;
        int pick;
        int n;
        w    = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        h    = $urandom_range(10, 1);
        pick = $urandom_range(99);
        // back to back frames keep the registers, otherwise rewrite one or both
        if (pick < 15 && !frame_open) begin
        end else if (pick < 30) begin
            configure(1'b0, 0, 1'b1, (h == 1 && $urandom_range(1)) ? 0 : h);
        end else begin
            configure(1'b1, (w == 1 && $urandom_range(1)) ? 0 : w, 1'b1, h);
        end
        n = ($urandom_range(9) == 0) ? $urandom_range(cur_w * cur_h, 1) : cur_w * cur_h;
        run_frame(n, 5, -1, -1);
        // drain ticks at the start of the next frame are ignored
        if (!frame_open && $urandom_range(4) == 0) begin
            repeat ($urandom_range(3, 1)) offer(1'b1, 24'($urandom));
        end
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: 3x3 frame with extreme pixels, early and late drain ticks
        idle_pct = 15;
        configure(1'b1, 3, 1'b1, 3);
        offer(1'b1, 24'h000000);
        offer(1'b0, 24'hFFFFFF);
        offer(1'b0, 24'h000000);
        offer(1'b0, 24'h0000FF);
        offer(1'b0, 24'h00FF00);
        offer(1'b0, 24'hFF0000);
        offer(1'b1, 24'hFFFFFF);
        offer(1'b0, 24'hFFFFFF);
        offer(1'b0, 24'hFFFFFF);
        offer(1'b0, 24'hFFFFFF);
        offer(1'b0, 24'h000000);
        for (int i = 0; i < 12; i++) begin
            offer(i[0], 24'hFFFFFF);
        end
        offer(1'b1, 24'h000000);

        // full output side hold mid-frame, then a sender pause
        configure(1'b1, 8, 1'b1, 8);
        run_frame(64, 0, 32, 56);

        // register extremes, clamping and the reset values
        idle_pct = 1;
        configure(1'b1, 0, 1'b1, 0);
        run_frame(1, 0, -1, -1);
        configure(1'b1, 4095, 1'b1, 1);
        run_frame(24, 2, -1, -1);
        configure(1'b1, MAX_WIDTH, 1'b1, 2);
        run_frame(24, 2, -1, -1);
        configure(1'b1, 1, 1'b1, 8191);
        run_frame(20, 2, -1, -1);
        configure(1'b0, 0, 1'b1, MAX_HEIGHT);
        run_frame(30, 2, -1, -1);
        configure(1'b1, RESET_WIDTH, 1'b1, RESET_HEIGHT);
        run_frame(30, 2, -1, -1);

        // random frames, the last few with no idling
        idle_pct   = 15;
        items_done = 0;
        while (items_done < RANDOM_ITEMS) random_frame();
        idle_pct = 0;
        repeat (3) random_frame();

        wait_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[rgb_box_blur_7x7] OK");
        end else begin
            $display("[rgb_box_blur_7x7] ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bbl_pkg.sv
hdl/bbl_line_buf.sv
hdl/bbl_window.sv
hdl/bbl_round49.sv
hdl/rgb_box_blur_7x7.sv
tb/sv/box_blur_checker.sv
tb/sv/testbench.sv
